// ===== src/sfr_pkg.sv =====
// shared types and register codes for the stream find-and-replace block
`default_nettype none

package sfr_pkg;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PATTERN_BYTES      = 3'd0,
		REG_PATTERN_LENGTH     = 3'd1,
		REG_REPLACEMENT_BYTES  = 3'd2,
		REG_REPLACEMENT_LENGTH = 3'd3,
		REG_REPLACE_LIMIT      = 3'd4
	} sfr_reg_t;

	typedef struct packed {
		logic [63:0] pattern_bytes;
		logic [3:0]  pattern_length;
		logic [63:0] replacement_bytes;
		logic [3:0]  replacement_length;
		logic [15:0] replace_limit;
	} sfr_cfg_t;

	// hand-off from the match stage to the output burst register
	typedef struct packed {
		logic load;
		logic fin;
	} sfr_burst_ctl_t;

endpackage

`default_nettype wire

// ===== src/stream_find_and_replace_core.sv =====
// Stream find-and-replace core.
//
// Input stream s_*: one byte word per handshake, s_tlast marks the final
// byte of a string. Output stream m_*: one byte word per handshake, with
// m_tuser[0] set for a data byte (clear for the bare end marker), m_tuser[1]
// set on the last word caused by one input word, and m_tlast on the last
// word of the output string.
// The cfg_* port writes pattern, lengths and limit; write it only while idle.
// An accepted byte waits in the input register while the held window is
// compared against the pattern in parallel; its results load the burst
// register once that is free, and the first result word is then on the
// port. Each input word yields zero to BURST_DEPTH words; with one result
// per input and a receiver that takes every word, the core sustains one
// word per cycle. A burst leaves the output port one word at a time; one
// more input word can wait in the input register, then input stalls until
// the last word of the burst is taken, so a stalled receiver holds the
// whole pipeline without loss.
// Reset clears the window, the replacement count and all valid flags and
// loads the register defaults (pattern length 1, empty replacement, no limit).
`default_nettype none

module stream_find_and_replace_core #(
	parameter int unsigned MAX_PATTERN_BYTES     = 8,
	parameter int unsigned MAX_REPLACEMENT_BYTES = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,  // in_byte
	input  wire logic                              s_tlast,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [7:0]                             m_tdata,  // out_byte
	output logic [1:0]                             m_tuser,  // out_has_data, out_run_end
	output logic                                   m_tlast,
	input  wire logic                              cfg_we,
	input  wire logic [sfr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import sfr_pkg::*;

	localparam int unsigned BURST_DEPTH = (MAX_PATTERN_BYTES > MAX_REPLACEMENT_BYTES) ?
		MAX_PATTERN_BYTES : MAX_REPLACEMENT_BYTES;
	localparam int unsigned COUNT_W = $clog2(BURST_DEPTH + 1);

	sfr_cfg_t                   cfg_q;
	sfr_burst_ctl_t             ctl;
	logic [BURST_DEPTH*8-1:0]   burst_bytes;
	logic [COUNT_W-1:0]         burst_count;
	logic                       burst_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes      <= 64'd0;
			cfg_q.pattern_length     <= 4'd1;
			cfg_q.replacement_bytes  <= 64'd0;
			cfg_q.replacement_length <= 4'd0;
			cfg_q.replace_limit      <= 16'd0;
		end else if (cfg_we) begin
			case (sfr_reg_t'(cfg_addr))
				REG_PATTERN_BYTES:      cfg_q.pattern_bytes      <= cfg_wdata;
				REG_PATTERN_LENGTH:     cfg_q.pattern_length     <= cfg_wdata[3:0];
				REG_REPLACEMENT_BYTES:  cfg_q.replacement_bytes  <= cfg_wdata;
				REG_REPLACEMENT_LENGTH: cfg_q.replacement_length <= cfg_wdata[3:0];
				REG_REPLACE_LIMIT:      cfg_q.replace_limit      <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	sfr_match #(
		.MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
		.MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES),
		.BURST_DEPTH           (BURST_DEPTH),
		.COUNT_W               (COUNT_W)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.cfg         (cfg_q),
		.burst_free  (burst_free),
		.ctl         (ctl),
		.burst_bytes (burst_bytes),
		.burst_count (burst_count)
	);

	sfr_out #(
		.BURST_DEPTH (BURST_DEPTH),
		.COUNT_W     (COUNT_W)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.burst_bytes (burst_bytes),
		.burst_count (burst_count),
		.burst_free  (burst_free),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

`default_nettype wire

// ===== src/sfr_match.sv =====
// input register, held window, pattern compare and next-state logic
`default_nettype none

module sfr_match #(
	parameter int unsigned MAX_PATTERN_BYTES     = 8,
	parameter int unsigned MAX_REPLACEMENT_BYTES = 8,
	parameter int unsigned BURST_DEPTH           = 8,
	parameter int unsigned COUNT_W               = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,
	input  wire logic                          s_tlast,
	input  wire sfr_pkg::sfr_cfg_t             cfg,
	input  wire logic                          burst_free,
	output sfr_pkg::sfr_burst_ctl_t            ctl,
	output logic [BURST_DEPTH*8-1:0]           burst_bytes,
	output logic [COUNT_W-1:0]                 burst_count
);
	import sfr_pkg::*;

	localparam int unsigned P  = MAX_PATTERN_BYTES;
	localparam int unsigned R  = MAX_REPLACEMENT_BYTES;
	localparam int unsigned CW = $clog2(P + 1);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              final_s1;

	logic [7:0]        win_q [P];
	logic [CW-1:0]     cnt_q;
	logic [15:0]       done_q;

	logic [3:0]        plen;
	logic [3:0]        rlen;
	logic [3:0]        c1;
	logic [7:0]        w1 [P];
	logic              match;
	logic              allowed;
	logic              over;
	logic              full;
	logic              replace;
	logic [3:0]        k;
	logic [3:0]        n_res;
	logic [7:0]        win_n [P];
	logic [3:0]        cnt_n;
	logic [15:0]       done_n;
	logic              advance;

	assign advance  = valid_s1 && burst_free;
	assign s_tready = !valid_s1 || burst_free;

	always_comb begin
		plen = cfg.pattern_length;
		if (cfg.pattern_length == 4'd0) begin
			plen = 4'd1;
		end else if (cfg.pattern_length > 4'(P)) begin
			plen = 4'(P);
		end
		rlen = (cfg.replacement_length > 4'(R)) ? 4'(R) : cfg.replacement_length;
	end

	always_comb begin
		c1 = 4'(cnt_q) + 4'd1;
		for (int i = 0; i < P; i++) begin
			w1[i] = (4'(i) == 4'(cnt_q)) ? byte_s1 : win_q[i];
		end

		match = 1'b1;
		for (int i = 0; i < P; i++) begin
			if ((4'(i) < plen) && (w1[i] != cfg.pattern_bytes[8*i +: 8])) begin
				match = 1'b0;
			end
		end

		allowed = (cfg.replace_limit == 16'd0) || (done_q < cfg.replace_limit);
		over    = c1 > plen;
		full    = c1 == plen;
		replace = full && allowed && match;

		// oldest bytes leaving the window on this word
		if (over) begin
			k = c1 - plen + 4'd1;
		end else if (full && !replace) begin
			k = 4'd1;
		end else begin
			k = 4'd0;
		end

		burst_bytes = '0;
		for (int i = 0; i < BURST_DEPTH; i++) begin
			if (replace) begin
				if (i < R) begin
					burst_bytes[8*i +: 8] = cfg.replacement_bytes[8*i +: 8];
				end
			end else if (i < P) begin
				burst_bytes[8*i +: 8] = w1[i];
			end
		end

		if (replace) begin
			n_res = rlen;
		end else if (final_s1) begin
			n_res = c1;
		end else begin
			n_res = k;
		end

		cnt_n = (replace || final_s1) ? 4'd0 : (c1 - k);
		for (int i = 0; i < P; i++) begin
			win_n[i] = 8'd0;
			if (!(replace || final_s1)) begin
				for (int j = 0; j < P; j++) begin
					if ((5'(i) + 5'(k)) == 5'(j)) begin
						win_n[i] = w1[j];
					end
				end
			end
		end

		if (final_s1) begin
			done_n = 16'd0;
		end else if (replace && (done_q != 16'hFFFF)) begin
			done_n = done_q + 16'd1;
		end else begin
			done_n = done_q;
		end
	end

	assign burst_count = COUNT_W'(n_res);
	assign ctl.load    = advance && ((n_res != 4'd0) || final_s1);
	assign ctl.fin     = final_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < P; i++) begin
				win_q[i] <= 8'd0;
			end
			cnt_q  <= '0;
			done_q <= 16'd0;
		end else if (advance) begin
			for (int i = 0; i < P; i++) begin
				win_q[i] <= win_n[i];
			end
			cnt_q  <= CW'(cnt_n);
			done_q <= done_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/sfr_out.sv =====
// output burst register that hands the result words out one per cycle while the receiver is ready
`default_nettype none

module sfr_out #(
	parameter int unsigned BURST_DEPTH = 8,
	parameter int unsigned COUNT_W     = 4
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sfr_pkg::sfr_burst_ctl_t   ctl,
	input  wire logic [BURST_DEPTH*8-1:0]  burst_bytes,
	input  wire logic [COUNT_W-1:0]        burst_count,
	output logic                           burst_free,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [7:0]                     m_tdata,
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);
	import sfr_pkg::*;

	localparam int unsigned IW = (BURST_DEPTH > 1) ? $clog2(BURST_DEPTH) : 1;

	logic [7:0]         bytes_q [BURST_DEPTH];
	logic [COUNT_W-1:0] n_q;
	logic [IW-1:0]      idx_q;
	logic               fin_q;
	logic               valid_q;
	logic               marker;
	logic               last;

	// a burst of zero words is the bare end marker
	assign marker     = n_q == '0;
	assign last       = marker || ((COUNT_W'(idx_q) + COUNT_W'(1)) == n_q);
	assign burst_free = !valid_q || (m_tready && last);

	assign m_tvalid = valid_q;
	assign m_tdata  = marker ? 8'd0 : bytes_q[idx_q];
	assign m_tuser  = {last, !marker};
	assign m_tlast  = fin_q && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && m_tready) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < BURST_DEPTH; i++) begin
				bytes_q[i] <= burst_bytes[8*i +: 8];
			end
			n_q   <= burst_count;
			fin_q <= ctl.fin;
		end
	end

endmodule

`default_nettype wire

// ===== src/sfr_check.sv =====
// port-level checks for the stream find-and-replace core, bound to the top
`default_nettype none

module sfr_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [1:0] m_tuser,
	input wire logic       m_tlast
);

	// a stalled word stays put
	a_stall_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_stall_hold_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tuser) && $stable(m_tlast))
		else $error("output flags changed while stalled");

	// the end of a string also ends the burst of its input word
	a_final_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[1])
		else $error("string end without burst end");

	// a word without data is only ever the bare end marker
	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && (m_tdata == 8'd0))
		else $error("malformed end marker");

endmodule

bind stream_find_and_replace_core sfr_check u_sfr_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the stream find-and-replace core
module tb;
	import sfr_pkg::*;

	localparam int unsigned WIN_BYTES      = 8;
	localparam int unsigned REPL_MAX       = 8;
	localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned PHASE_WORDS    = 26;

	typedef struct packed {
		logic [7:0] data;
		logic       has_data;
		logic       is_final;
		logic       run_end;
	} out_word_t;

	typedef enum logic {
		ROW_CFG,
		ROW_WORD
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		sfr_reg_t    addr;
		logic [63:0] value;
		logic [7:0]  data;
		logic        fin;
		logic        typed;
		out_word_t   want;
	} stim_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [7:0]            m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic idle_en    = 1'b1;
	logic hold_phase = 1'b0;
	int unsigned err_count   = 0;
	int unsigned cycle_count = 0;

	// predictor copy of the registers and the held window
	logic [63:0] cur_pattern  = '0;
	logic [3:0]  cur_pat_len  = 4'd1;
	logic [63:0] cur_repl     = '0;
	logic [3:0]  cur_repl_len = '0;
	logic [15:0] cur_limit    = '0;
	logic [7:0]  held_bytes [WIN_BYTES];
	int unsigned held_cnt  = 0;
	logic [15:0] repl_done = '0;

	out_word_t step_words[$];
	out_word_t expected_words[$];
	stim_row_t directed_rows[$];

	stream_find_and_replace_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycle_count < TIMEOUT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	task automatic release_oldest();
		out_word_t w;
		w = {held_bytes[0], 1'b1, 1'b0, 1'b0};
		step_words = {step_words, w};
		for (int k = 0; k < WIN_BYTES - 1; k++)
			held_bytes[k] = held_bytes[k + 1];
		held_bytes[WIN_BYTES - 1] = '0;
		held_cnt--;
	endtask

	// results of one input byte, left in step_words
	task automatic find_replace_step(input logic [7:0] b, input logic fin);
		int unsigned plen;
		int unsigned rlen;
		logic        allowed;
		logic        hit;
		out_word_t   w;
		step_words.delete();
		plen = (cur_pat_len == 0) ? 1 : ((cur_pat_len > WIN_BYTES) ? WIN_BYTES : cur_pat_len);
		rlen = (cur_repl_len > REPL_MAX) ? REPL_MAX : cur_repl_len;
		if (held_cnt < WIN_BYTES) begin
			held_bytes[held_cnt] = b;
			held_cnt++;
		end
		if (held_cnt > plen) begin
			// pattern got shorter: drain down to one byte short of it, no compare
			while (held_cnt > plen - 1)
				release_oldest();
		end else if (held_cnt == plen) begin
			allowed = (cur_limit == 0) || (repl_done < cur_limit);
			hit = 1'b1;
			for (int k = 0; k < plen; k++)
				if (held_bytes[k] != cur_pattern[8*k +: 8])
					hit = 1'b0;
			if (allowed && hit) begin
				for (int k = 0; k < rlen; k++) begin
					w = {cur_repl[8*k +: 8], 1'b1, 1'b0, 1'b0};
					step_words = {step_words, w};
				end
				held_cnt = 0;
				if (repl_done != 16'hFFFF)
					repl_done++;
			end else begin
				release_oldest();
			end
		end
		if (fin) begin
			while (held_cnt > 0)
				release_oldest();
			repl_done = '0;
			if (step_words.size() == 0) begin
				w = '0;
				step_words = {step_words, w};
			end
			w = step_words.pop_back();
			w.is_final = 1'b1;
			step_words = {step_words, w};
		end
		if (step_words.size() != 0) begin
			w = step_words.pop_back();
			w.run_end = 1'b1;
			step_words = {step_words, w};
		end
	endtask

	task automatic send_word(input logic [7:0] b, input logic fin, input logic typed,
			input out_word_t want);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		find_replace_step(b, fin);
		if (typed)
			expected_words = {expected_words, want};
		else
			expected_words = {expected_words, step_words};
	endtask

	// wait until the core has nothing left in flight
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input sfr_reg_t idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PATTERN_BYTES:      cur_pattern  = val;
			REG_PATTERN_LENGTH:     cur_pat_len  = val[3:0];
			REG_REPLACEMENT_BYTES:  cur_repl     = val;
			REG_REPLACEMENT_LENGTH: cur_repl_len = val[3:0];
			REG_REPLACE_LIMIT:      cur_limit    = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic add_cfg(input sfr_reg_t idx, input logic [63:0] val);
		stim_row_t r;
		r = '{ROW_CFG, idx, val, 8'h00, 1'b0, 1'b0, '0};
		directed_rows = {directed_rows, r};
	endtask

	task automatic add_word(input logic [7:0] b, input logic fin);
		stim_row_t r;
		r = '{ROW_WORD, REG_PATTERN_BYTES, 64'd0, b, fin, 1'b0, '0};
		directed_rows = {directed_rows, r};
	endtask

	// single-result row whose result is obvious
	task automatic add_checked(input logic [7:0] b, input logic fin, input logic [7:0] t_data,
			input logic t_has);
		stim_row_t r;
		r = '{ROW_WORD, REG_PATTERN_BYTES, 64'd0, b, fin, 1'b1, {t_data, t_has, fin, 1'b1}};
		directed_rows = {directed_rows, r};
	endtask

	task automatic random_config();
		logic [63:0] pat;
		int unsigned sel;
		settle();
		if ($urandom_range(0, 2) != 0) begin
			if ($urandom_range(0, 1) != 0)
				pat = {$urandom, $urandom};
			else
				// two-letter alphabet gives overlapping and partial matches
				for (int k = 0; k < 8; k++)
					pat[8*k +: 8] = ($urandom_range(0, 1) != 0) ? 8'h61 : 8'h62;
			write_reg(REG_PATTERN_BYTES, pat);
		end
		if ($urandom_range(0, 3) != 0) begin
			sel = $urandom_range(0, 19);
			if (sel < 14)
				write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(1, 4)));
			else if (sel < 17)
				write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(5, 8)));
			else if (sel == 17)
				write_reg(REG_PATTERN_LENGTH, 64'd0);
			else
				write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(9, 15)));
		end
		if ($urandom_range(0, 1) != 0)
			write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
		if ($urandom_range(0, 1) != 0) begin
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_REPLACEMENT_LENGTH, 64'($urandom_range(0, 3)));
			else
				write_reg(REG_REPLACEMENT_LENGTH, 64'($urandom_range(0, 15)));
		end
		if ($urandom_range(0, 1) != 0) begin
			sel = $urandom_range(0, 9);
			if (sel < 4)
				write_reg(REG_REPLACE_LIMIT, 64'd0);
			else if (sel < 8)
				write_reg(REG_REPLACE_LIMIT, 64'($urandom_range(1, 3)));
			else if (sel == 8)
				write_reg(REG_REPLACE_LIMIT, 64'hFFFF);
			else
				write_reg(REG_REPLACE_LIMIT, 64'($urandom_range(0, 65535)));
		end
	endtask

	// text built mostly from the pattern, with broken copies and noise bytes
	task automatic run_text_phase(input int unsigned n_words);
		logic [7:0]  pending[$];
		int unsigned plen;
		int unsigned sent;
		logic [7:0]  b;
		plen = (cur_pat_len == 0) ? 1 : ((cur_pat_len > WIN_BYTES) ? WIN_BYTES : cur_pat_len);
		sent = 0;
		while (sent < n_words) begin
			if (pending.size() == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						for (int k = 0; k < plen; k++)
							pending = {pending, cur_pattern[8*k +: 8]};
						if ($urandom_range(0, 3) == 0)
							pending[$urandom_range(0, plen - 1)] = 8'($urandom_range(0, 255));
					end
					4, 5, 6: pending = {pending, cur_pattern[8*$urandom_range(0, plen - 1) +: 8]};
					default: pending = {pending, 8'($urandom_range(0, 255))};
				endcase
			end
			b = pending.pop_front();
			send_word(b, $urandom_range(0, 9) == 0, 1'b0, '0);
			sent++;
		end
	endtask

	// output side: random stalls, one long hold-off, and the scoreboard
	initial begin
		int unsigned stall_left;
		int unsigned hold_left;
		logic        hold_done;
		out_word_t   got;
		out_word_t   want;
		stall_left = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = {m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
				if (expected_words.size() == 0) begin
					err_count++;
					$display("%0t: mismatch: expected no word, actual data=%02h has_data=%0b last=%0b run_end=%0b",
						$time, got.data, got.has_data, got.is_final, got.run_end);
				end else begin
					want = expected_words.pop_front();
					if (got.data !== want.data || got.has_data !== want.has_data ||
							got.is_final !== want.is_final || got.run_end !== want.run_end) begin
						err_count++;
						$display("%0t: mismatch: expected data=%02h has_data=%0b last=%0b run_end=%0b, actual data=%02h has_data=%0b last=%0b run_end=%0b",
							$time, want.data, want.has_data, want.is_final, want.run_end,
							got.data, got.has_data, got.is_final, got.run_end);
					end
				end
			end
			if (hold_phase && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (!hold_phase)
				hold_done = 1'b0;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		foreach (held_bytes[k])
			held_bytes[k] = '0;

		// defaults after reset: a lone zero byte is deleted, then the end marker
		add_checked(8'h00, 1'b1, 8'h00, 1'b0);
		add_checked(8'hFF, 1'b1, 8'hFF, 1'b1);
		add_cfg(REG_PATTERN_BYTES, 64'h6261);
		add_cfg(REG_PATTERN_LENGTH, 64'd2);
		add_cfg(REG_REPLACEMENT_BYTES, 64'h5A5958);
		add_cfg(REG_REPLACEMENT_LENGTH, 64'd3);
		add_cfg(REG_REPLACE_LIMIT, 64'd1);
		add_word(8'h61, 1'b0);
		add_word(8'h62, 1'b0);
		// second match is past the limit and passes through
		add_word(8'h61, 1'b0);
		add_word(8'h62, 1'b0);
		add_word(8'h63, 1'b1);
		// count starts over on a new string
		add_word(8'h61, 1'b0);
		add_word(8'h62, 1'b0);
		add_cfg(REG_REPLACE_LIMIT, 64'd0);
		add_word(8'h61, 1'b0);
		add_word(8'h62, 1'b0);
		// limit dropped below the count already reached in this string
		add_cfg(REG_REPLACE_LIMIT, 64'd1);
		add_word(8'h61, 1'b0);
		add_word(8'h62, 1'b0);
		add_word(8'h62, 1'b1);
		// zero pattern length acts as one, oversize replacement clips to eight bytes
		add_cfg(REG_PATTERN_LENGTH, 64'd0);
		add_cfg(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
		add_cfg(REG_REPLACEMENT_LENGTH, 64'd15);
		add_cfg(REG_REPLACEMENT_BYTES, 64'h00FF_00FF_00FF_00FF);
		add_cfg(REG_REPLACE_LIMIT, 64'hFFFF);
		add_word(8'hFF, 1'b0);
		add_checked(8'h00, 1'b1, 8'h00, 1'b1);
		// oversize pattern length clips to eight, window fills to seven
		add_cfg(REG_PATTERN_BYTES, 64'h0706_0504_0302_0100);
		add_cfg(REG_PATTERN_LENGTH, 64'd15);
		add_cfg(REG_REPLACEMENT_LENGTH, 64'd0);
		for (int k = 0; k < 7; k++)
			add_word(k[7:0], 1'b0);
		// pattern shortened while seven bytes are held
		add_cfg(REG_PATTERN_LENGTH, 64'd2);
		add_word(8'h07, 1'b0);
		add_word(8'h07, 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				settle();
				write_reg(directed_rows[i].addr, directed_rows[i].value);
			end else begin
				send_word(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		for (int p = 0; p < 7; p++) begin
			random_config();
			idle_en    <= (p != 3) && (p < 6);
			hold_phase <= (p == 2);
			run_text_phase(PHASE_WORDS);
		end

		// single-byte pattern with the limit at its top value
		settle();
		hold_phase <= 1'b0;
		idle_en    <= 1'b0;
		write_reg(REG_PATTERN_BYTES, 64'h5A);
		write_reg(REG_PATTERN_LENGTH, 64'd1);
		write_reg(REG_REPLACEMENT_BYTES, 64'hA5);
		write_reg(REG_REPLACEMENT_LENGTH, 64'd1);
		write_reg(REG_REPLACE_LIMIT, 64'hFFFF);
		send_word(8'h5A, 1'b0, 1'b0, '0);
		send_word(8'h5A, 1'b1, 1'b0, '0);
		settle();

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
